// ----- design/clgm_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clgm_pkg
// Shared types, codes and helpers for the cached lock grant manager.
// ----------------------------------------------------------------------------
package clgm_pkg;

   localparam int LOCK_COUNT   = 16;
   localparam int CLIENT_COUNT = 8;
   localparam int TXN_BITS     = 32;

   localparam int LOCK_BITS    = $clog2(LOCK_COUNT);
   localparam int CLIENT_BITS  = $clog2(CLIENT_COUNT);
   localparam int PAIR_BITS    = LOCK_BITS + CLIENT_BITS;
   localparam int PAIR_COUNT   = LOCK_COUNT * CLIENT_COUNT;
   localparam int REPLY_BITS   = 2;
   // transaction number, acquire reply, release reply
   localparam int WORD_BITS    = TXN_BITS + 2 * REPLY_BITS;

   typedef logic [LOCK_BITS-1:0]    lock_id_type;
   typedef logic [CLIENT_BITS-1:0]  client_id_type;
   typedef logic [TXN_BITS-1:0]     txn_type;
   typedef logic [PAIR_BITS-1:0]    pair_type;
   typedef logic [CLIENT_COUNT-1:0] waiters_type;
   typedef logic [REPLY_BITS-1:0]   status_type;
   typedef logic [1:0]              mode_type;
   typedef logic [1:0]              kind_type;
   typedef logic                    action_type;

   localparam action_type ACT_ACQUIRE = 1'b0;
   localparam action_type ACT_RELEASE = 1'b1;

   localparam status_type ST_OK       = 2'd0;
   localparam status_type ST_RETRY    = 2'd1;
   localparam status_type ST_PROTO    = 2'd2;
   localparam status_type ST_NOTOWNER = 2'd3;

   localparam mode_type MODE_FREE     = 2'd0;
   localparam mode_type MODE_LOCKED   = 2'd1;
   localparam mode_type MODE_WAITING  = 2'd2;
   localparam mode_type MODE_RETRYING = 2'd3;

   localparam kind_type MSG_NONE   = 2'd0;
   localparam kind_type MSG_REVOKE = 2'd1;
   localparam kind_type MSG_RETRY  = 2'd2;

   typedef struct packed {
      mode_type      mode;
      client_id_type holder;
      waiters_type   waiters;
   } lock_entry_type;

   // request held in the stage register, with its lock entry and message target
   typedef struct packed {
      action_type     action;
      lock_id_type    lock_id;
      client_id_type  client_id;
      txn_type        txn;
      lock_entry_type ent;
      client_id_type  tgt;
   } stage_type;

   // per (lock, client) view of the requester plus the target's number
   typedef struct packed {
      logic       seen;
      logic       rel_valid;
      txn_type    txn;
      status_type acq_reply;
      status_type rel_reply;
      txn_type    tgt_txn;
   } pair_view_type;

   typedef struct packed {
      status_type     status;
      kind_type       kind;
      client_id_type  msg_client;
      lock_id_type    msg_lock;
      txn_type        msg_txn;
      logic           ent_we;
      lock_entry_type ent;
      logic           txn_we;
      logic           rel_we;
   } decide_type;

   function automatic client_id_type lowest_waiter(input waiters_type mask);
      client_id_type c;
      c = '0;
      for (int i = CLIENT_COUNT - 1; i >= 0; i--) begin
         if (mask[i]) begin
            c = client_id_type'(i);
         end
      end
      return c;
   endfunction

endpackage

// ----- design/clgm_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clgm_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
module clgm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- design/clgm_decide.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clgm_decide
// Grant decision for one request: reply, message and state updates.
// ----------------------------------------------------------------------------
module clgm_decide (
   input  clgm_pkg::stage_type     stg,
   input  clgm_pkg::pair_view_type pv,
   output clgm_pkg::decide_type    dec
);
   import clgm_pkg::*;

   waiters_type    bit_mask;
   waiters_type    remaining;
   logic           held;
   status_type     st;
   kind_type       kind;
   client_id_type  tgt;
   lock_entry_type ent;
   logic           ent_we;
   logic           txn_we;
   logic           rel_we;

   assign bit_mask  = waiters_type'(1) << stg.client_id;
   assign remaining = stg.ent.waiters & ~bit_mask;
   assign held      = (stg.ent.mode == MODE_LOCKED) || (stg.ent.mode == MODE_WAITING);

   always_comb begin
      st     = ST_OK;
      kind   = MSG_NONE;
      tgt    = '0;
      ent    = stg.ent;
      ent_we = 1'b0;
      txn_we = 1'b0;
      rel_we = 1'b0;
      if (stg.action == ACT_ACQUIRE) begin
         priority if (!pv.seen || (pv.txn < stg.txn)) begin
            txn_we = 1'b1;
            ent_we = 1'b1;
            unique case (stg.ent.mode)
               MODE_FREE: begin
                  ent.mode   = MODE_LOCKED;
                  ent.holder = stg.client_id;
               end
               MODE_LOCKED, MODE_WAITING: begin
                  ent.mode    = MODE_WAITING;
                  ent.waiters = stg.ent.waiters | bit_mask;
                  kind        = MSG_REVOKE;
                  tgt         = stg.tgt;
                  st          = ST_RETRY;
               end
               MODE_RETRYING: begin
                  if ((stg.ent.waiters & bit_mask) != '0) begin
                     ent.waiters = remaining;
                     ent.holder  = stg.client_id;
                     if (remaining != '0) begin
                        ent.mode = MODE_WAITING;
                        kind     = MSG_REVOKE;
                        tgt      = stg.client_id;
                     end else begin
                        ent.mode = MODE_LOCKED;
                     end
                  end else begin
                     ent.waiters = stg.ent.waiters | bit_mask;
                     st          = ST_RETRY;
                  end
               end
               default: begin
                  ent_we = 1'b0;
               end
            endcase
         end else if (pv.txn > stg.txn) begin
            st = ST_PROTO;
         end else begin
            st = pv.acq_reply;
         end
      end else begin
         priority if (!pv.seen || (pv.txn != stg.txn)) begin
            st = ST_PROTO;
         end else if (pv.rel_valid) begin
            st = pv.rel_reply;
         end else begin
            rel_we = 1'b1;
            if (!held || (stg.ent.holder != stg.client_id)) begin
               st = ST_NOTOWNER;
            end else if ((stg.ent.mode == MODE_WAITING) && (stg.ent.waiters != '0)) begin
               ent_we     = 1'b1;
               ent.mode   = MODE_RETRYING;
               ent.holder = '0;
               kind       = MSG_RETRY;
               tgt        = stg.tgt;
            end else begin
               ent_we     = 1'b1;
               ent.mode   = MODE_FREE;
               ent.holder = '0;
            end
         end
      end
   end

   // the requester's own number is always the request's number when it is the target
   always_comb begin
      dec.status = st;
      dec.kind   = kind;
      dec.ent_we = ent_we;
      dec.ent    = ent;
      dec.txn_we = txn_we;
      dec.rel_we = rel_we;
      if (kind == MSG_NONE) begin
         dec.msg_client = '0;
         dec.msg_lock   = '0;
         dec.msg_txn    = '0;
      end else begin
         dec.msg_client = tgt;
         dec.msg_lock   = stg.lock_id;
         dec.msg_txn    = (tgt == stg.client_id) ? stg.txn : pv.tgt_txn;
      end
   end

endmodule

// ----- design/cached_lock_grant_manager.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cached_lock_grant_manager
// Lock grant manager with duplicate detection and revoke / retry messages.
// ----------------------------------------------------------------------------
// Every request word gives exactly one response word. A request is taken in
// every cycle while the response side keeps up. When a request is accepted,
// the per (lock, client) transaction RAMs do their registered read and the
// lock entry is captured with the request in the stage register. When the
// stage advances, the decision lands in the response register. A request
// waits only while the stage is full and the response register is full and
// stalled. Back-to-back requests to the same lock or (lock, client) pair are
// forwarded, so there is no hazard stall. No clearing pass follows reset.
// ----------------------------------------------------------------------------
module cached_lock_grant_manager (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  clgm_pkg::action_type     req_action,
   input  clgm_pkg::lock_id_type    req_lock_id,
   input  clgm_pkg::client_id_type  req_client_id,
   input  clgm_pkg::txn_type        req_txn_number,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output clgm_pkg::status_type     rsp_reply_status,
   output clgm_pkg::kind_type       rsp_message_kind,
   output clgm_pkg::client_id_type  rsp_message_client,
   output clgm_pkg::lock_id_type    rsp_message_lock,
   output clgm_pkg::txn_type        rsp_message_txn
);
   import clgm_pkg::*;

   logic           s_vld_ff, s_vld_in;
   stage_type      s_ff;
   stage_type      s_in;
   logic           advance;
   logic           accept;
   pair_type       s_pair;
   pair_type       req_pair;
   pair_type       tgt_pair;

   lock_entry_type lock_tab_ff [LOCK_COUNT];
   lock_entry_type lock_tab_in [LOCK_COUNT];
   lock_entry_type ent_rd;
   logic [PAIR_COUNT-1:0] seen_ff, seen_in;
   logic [PAIR_COUNT-1:0] relv_ff, relv_in;

   logic [WORD_BITS-1:0] ram_a_q;
   logic [WORD_BITS-1:0] wr_a_data;
   logic [WORD_BITS-1:0] a_word;
   logic                 wr_a_en;
   txn_type              ram_b_q;
   logic                 wr_b_en;
   logic                 byp_a_ff;
   logic [WORD_BITS-1:0] byp_a_data_ff;
   logic                 byp_b_ff;
   txn_type              byp_b_data_ff;

   pair_view_type  pv;
   decide_type     dec;

   logic           rsp_valid_ff, rsp_valid_in;
   status_type     rsp_status_ff;
   kind_type       rsp_kind_ff;
   client_id_type  rsp_client_ff;
   lock_id_type    rsp_lock_ff;
   txn_type        rsp_txn_ff;

   assign advance   = s_vld_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = s_vld_ff && !advance;
   assign accept    = req_valid && !req_stall;

   assign s_pair   = {s_ff.lock_id, s_ff.client_id};
   assign req_pair = {req_lock_id, req_client_id};

   // take the lock entry as the item in the stage leaves it
   always_comb begin
      if (advance && dec.ent_we && (s_ff.lock_id == req_lock_id)) begin
         ent_rd = dec.ent;
      end else begin
         ent_rd = lock_tab_ff[req_lock_id];
      end
   end

   always_comb begin
      s_in.action    = req_action;
      s_in.lock_id   = req_lock_id;
      s_in.client_id = req_client_id;
      s_in.txn       = req_txn_number;
      s_in.ent       = ent_rd;
      s_in.tgt       = (req_action == ACT_RELEASE) ? lowest_waiter(ent_rd.waiters)
                                                   : ent_rd.holder;
   end

   assign tgt_pair = {req_lock_id, s_in.tgt};

   // transaction word RAM at the requester, copy of the numbers at the target
   assign wr_a_en   = advance && (dec.txn_we || dec.rel_we);
   assign wr_a_data = dec.txn_we ? {s_ff.txn, dec.status, a_word[REPLY_BITS-1:0]}
                                 : {a_word[WORD_BITS-1:REPLY_BITS], dec.status};
   assign wr_b_en   = advance && dec.txn_we;

   clgm_ram #(
      .WIDTH (WORD_BITS),
      .DEPTH (PAIR_COUNT)
   ) u_pair_ram (
      .clock   (clock),
      .wr_en   (wr_a_en),
      .wr_addr (s_pair),
      .wr_data (wr_a_data),
      .rd_en   (accept),
      .rd_addr (req_pair),
      .rd_data (ram_a_q)
   );

   clgm_ram #(
      .WIDTH (TXN_BITS),
      .DEPTH (PAIR_COUNT)
   ) u_target_ram (
      .clock   (clock),
      .wr_en   (wr_b_en),
      .wr_addr (s_pair),
      .wr_data (s_ff.txn),
      .rd_en   (accept),
      .rd_addr (tgt_pair),
      .rd_data (ram_b_q)
   );

   assign a_word = byp_a_ff ? byp_a_data_ff : ram_a_q;

   always_comb begin
      pv.seen      = seen_ff[s_pair];
      pv.rel_valid = relv_ff[s_pair];
      pv.txn       = a_word[WORD_BITS-1:2*REPLY_BITS];
      pv.acq_reply = a_word[2*REPLY_BITS-1:REPLY_BITS];
      pv.rel_reply = a_word[REPLY_BITS-1:0];
      pv.tgt_txn   = byp_b_ff ? byp_b_data_ff : ram_b_q;
   end

   clgm_decide u_decide (
      .stg (s_ff),
      .pv  (pv),
      .dec (dec)
   );

   always_comb begin
      lock_tab_in = lock_tab_ff;
      seen_in     = seen_ff;
      relv_in     = relv_ff;
      if (advance) begin
         if (dec.ent_we) begin
            lock_tab_in[s_ff.lock_id] = dec.ent;
         end
         if (dec.txn_we) begin
            seen_in[s_pair] = 1'b1;
            relv_in[s_pair] = 1'b0;
         end
         if (dec.rel_we) begin
            relv_in[s_pair] = 1'b1;
         end
      end
   end

   assign s_vld_in     = accept || (s_vld_ff && !advance);
   assign rsp_valid_in = advance || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         s_vld_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
         seen_ff      <= '0;
         relv_ff      <= '0;
         byp_a_ff     <= 1'b0;
         byp_b_ff     <= 1'b0;
         for (int i = 0; i < LOCK_COUNT; i++) begin
            lock_tab_ff[i] <= '{mode: MODE_FREE, holder: '0, waiters: '0};
         end
      end else begin
         s_vld_ff     <= s_vld_in;
         rsp_valid_ff <= rsp_valid_in;
         seen_ff      <= seen_in;
         relv_ff      <= relv_in;
         lock_tab_ff  <= lock_tab_in;
         if (accept) begin
            // catch a write landing on the address being read
            byp_a_ff <= wr_a_en && (s_pair == req_pair);
            byp_b_ff <= wr_b_en && (s_pair == tgt_pair);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s_ff          <= s_in;
         byp_a_data_ff <= wr_a_data;
         byp_b_data_ff <= s_ff.txn;
      end
      if (advance) begin
         rsp_status_ff <= dec.status;
         rsp_kind_ff   <= dec.kind;
         rsp_client_ff <= dec.msg_client;
         rsp_lock_ff   <= dec.msg_lock;
         rsp_txn_ff    <= dec.msg_txn;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_reply_status   = rsp_status_ff;
   assign rsp_message_kind   = rsp_kind_ff;
   assign rsp_message_client = rsp_client_ff;
   assign rsp_message_lock   = rsp_lock_ff;
   assign rsp_message_txn    = rsp_txn_ff;

endmodule
